// ===== sv/uvs_pkg.sv =====
// Shared widths, constants, register codes and helper functions for the UV sphere generator.
`timescale 1ns / 1ps

package uvs_pkg;

    // Field widths.
    localparam int CNT_W = 11;
    localparam int IDX_W = 11;
    localparam int RAD_W = 16;
    localparam int NRM_W = 16;
    localparam int POS_W = 17;
    localparam int TEX_W = 17;

    // Parameter defaults.
    localparam int MAX_STEPS_DEF  = 1024;
    localparam int ANGLE_BITS_DEF = 16;

    // Configuration register codes (word index of the APB address).
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_LON    = 2'd1;
    localparam logic [1:0] REG_LAT    = 2'd2;

    // Reset values of the registers.
    localparam logic [RAD_W-1:0] RADIUS_RST = 16'd256;
    localparam logic [CNT_W-1:0] LON_RST    = 11'd32;
    localparam logic [CNT_W-1:0] LAT_RST    = 11'd16;

    // Quarter sine constants: pi/2 in Q2.30 and one in Q2.30.
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] ONE_Q30     = 31'd1073741824;

    // Reciprocals 2^32/k for the series divisors 72, 42, 20 and 6.
    localparam logic [32:0] Two32     = 33'h1_0000_0000;
    localparam logic [32:0] RECIP_72  = Two32 / 72;
    localparam logic [32:0] RECIP_42  = Two32 / 42;
    localparam logic [32:0] RECIP_20  = Two32 / 20;
    localparam logic [32:0] RECIP_6   = Two32 / 6;

    // Pipeline depth of the quarter sine unit.
    localparam int QS_LAT = 16;

    // Occupancy flags of the queue between front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Series divisor for step j of the Horner evaluation.
    function automatic logic [6:0] step_div(input int j);
        logic [6:0] k;
        case (j)
            0:       k = 7'd72;
            1:       k = 7'd42;
            2:       k = 7'd20;
            default: k = 7'd6;
        endcase
        return k;
    endfunction

    // Reciprocal of the series divisor for step j.
    function automatic logic [29:0] step_recip(input int j);
        logic [29:0] r;
        case (j)
            0:       r = RECIP_72[29:0];
            1:       r = RECIP_42[29:0];
            2:       r = RECIP_20[29:0];
            default: r = RECIP_6[29:0];
        endcase
        return r;
    endfunction

    // Product divided by 2^14, rounded to nearest with ties away from zero.
    function automatic logic signed [17:0] mul_rnd14(input logic signed [17:0] a,
                                                     input logic signed [17:0] b);
        logic        neg;
        logic [17:0] ma;
        logic [17:0] mb;
        logic [35:0] p;
        logic [17:0] m;
        neg = a[17] ^ b[17];
        ma  = a[17] ? 18'(-a) : 18'(a);
        mb  = b[17] ? 18'(-b) : 18'(b);
        p   = 36'(ma) * 36'(mb) + 36'd8192;
        m   = p[31:14];
        return neg ? -$signed(m) : $signed(m);
    endfunction

endpackage

// ===== sv/uvs_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module uvs_div #(
    parameter int NW = 29,
    parameter int QW = 17,
    parameter int DW = 11
) (
    input  logic          clk,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    logic [DW-1:0] rem_reg [0:QW-1];
    logic [QW-1:0] low_reg [0:QW-1];
    logic [QW-1:0] quo_reg [0:QW-1];
    logic [DW-1:0] den_reg [0:QW-1];

    genvar i;
    generate
        for (i = 0; i < QW; i++)
        begin : g_stage
            logic [DW-1:0] rem_in;
            logic [QW-1:0] low_in;
            logic [QW-1:0] quo_in;
            logic [DW-1:0] den_in;
            logic [DW:0]   trial;
            logic          ge;
            logic [DW:0]   diff;
            logic [DW-1:0] rem_next;
            logic [QW-1:0] low_next;
            logic [QW-1:0] quo_next;

            // The quotient fits in QW bits, so the upper numerator part is below the divisor.
            if (i == 0)
            begin : g_first
                always_comb
                begin
                    rem_in = num[QW+DW-1:QW];
                    low_in = num[QW-1:0];
                    quo_in = '0;
                    den_in = den;
                end
            end
            else
            begin : g_next
                always_comb
                begin
                    rem_in = rem_reg[i-1];
                    low_in = low_reg[i-1];
                    quo_in = quo_reg[i-1];
                    den_in = den_reg[i-1];
                end
            end

            // Shift in one numerator bit and subtract the divisor when it fits.
            always_comb
            begin
                trial    = {rem_in, low_in[QW-1]};
                ge       = (trial >= {1'b0, den_in});
                diff     = trial - {1'b0, den_in};
                rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
                low_next = {low_in[QW-2:0], 1'b0};
                quo_next = {quo_in[QW-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                rem_reg[i] <= rem_next;
                low_reg[i] <= low_next;
                quo_reg[i] <= quo_next;
                den_reg[i] <= den_in;
            end
        end
    endgenerate

    assign quo = quo_reg[QW-1];

endmodule

// ===== sv/uvs_front.sv =====
// Front end: clamps the grid indices and divides them into texture coordinates and phases.
`timescale 1ns / 1ps

module uvs_front #(
    parameter int MAX_STEPS  = uvs_pkg::MAX_STEPS_DEF,
    parameter int ANGLE_BITS = uvs_pkg::ANGLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  logic [uvs_pkg::IDX_W-1:0]   lat_index,
    input  logic [uvs_pkg::IDX_W-1:0]   lon_index,
    input  logic [uvs_pkg::CNT_W-1:0]   longitude_count,
    input  logic [uvs_pkg::CNT_W-1:0]   latitude_count,
    output logic                        out_valid,
    output logic [uvs_pkg::TEX_W-1:0]   tex_u,
    output logic [uvs_pkg::TEX_W-1:0]   tex_v,
    output logic [ANGLE_BITS-1:0]       theta,
    output logic [ANGLE_BITS-1:0]       phi
);

    localparam int QW = (ANGLE_BITS + 1 > 17) ? ANGLE_BITS + 1 : 17;
    localparam int NW = QW + 12;
    localparam int CW = uvs_pkg::CNT_W;

    logic [CW-1:0] lc;
    logic [CW-1:0] mc;
    logic [CW-1:0] a;
    logic [CW-1:0] b;

    logic [NW-1:0] num_u_reg, num_v_reg, num_t_reg, num_p_reg;
    logic [NW-1:0] num_u_next, num_v_next, num_t_next, num_p_next;
    logic [CW-1:0] lc_reg, mc_reg;
    logic [QW:0]   vld_reg;
    logic [QW:0]   vld_next;

    logic [QW-1:0] quo_u, quo_v, quo_t, quo_p;

    // Effective count: zero acts as one, large counts are limited to the step maximum.
    function automatic logic [CW-1:0] eff_count(input logic [CW-1:0] c);
        logic [CW-1:0] e;
        if (c == '0)
            e = CW'(1);
        else if (32'(c) > 32'(MAX_STEPS))
            e = CW'(MAX_STEPS);
        else
            e = c;
        return e;
    endfunction

    // Clamp the indices and form the rounded numerators.
    always_comb
    begin
        lc = eff_count(latitude_count);
        mc = eff_count(longitude_count);
        a  = (lat_index > lc) ? lc : lat_index;
        b  = (lon_index > mc) ? mc : lon_index;
        num_u_next = (NW'(b) << 16) + NW'(mc >> 1);
        num_v_next = (NW'(a) << 16) + NW'(lc >> 1);
        num_t_next = (NW'(b) << ANGLE_BITS) + NW'(mc >> 1);
        num_p_next = (NW'(a) << (ANGLE_BITS - 1)) + NW'(lc >> 1);
        vld_next   = {vld_reg[QW-1:0], take};
    end

    always_ff @(posedge clk)
    begin
        num_u_reg <= num_u_next;
        num_v_reg <= num_v_next;
        num_t_reg <= num_t_next;
        num_p_reg <= num_p_next;
        lc_reg    <= lc;
        mc_reg    <= mc;
    end

    // Valid bits follow the transactions through the divider stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    uvs_div #(.NW(NW), .QW(QW), .DW(CW)) u_div_u (
        .clk(clk), .num(num_u_reg), .den(mc_reg), .quo(quo_u)
    );
    uvs_div #(.NW(NW), .QW(QW), .DW(CW)) u_div_v (
        .clk(clk), .num(num_v_reg), .den(lc_reg), .quo(quo_v)
    );
    uvs_div #(.NW(NW), .QW(QW), .DW(CW)) u_div_t (
        .clk(clk), .num(num_t_reg), .den(mc_reg), .quo(quo_t)
    );
    uvs_div #(.NW(NW), .QW(QW), .DW(CW)) u_div_p (
        .clk(clk), .num(num_p_reg), .den(lc_reg), .quo(quo_p)
    );

    // The theta phase wraps to one full turn; v counts down from one.
    assign out_valid = vld_reg[QW];
    assign tex_u     = quo_u[uvs_pkg::TEX_W-1:0];
    assign tex_v     = 17'd65536 - quo_v[uvs_pkg::TEX_W-1:0];
    assign theta     = quo_t[ANGLE_BITS-1:0];
    assign phi       = quo_p[ANGLE_BITS-1:0];

endmodule

// ===== sv/uvs_queue.sv =====
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps

module uvs_queue #(
    parameter int W = 66
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [W-1:0]     push_data,
    input  logic             pop,
    output logic [W-1:0]     pop_data,
    output uvs_pkg::q_stat_t stat
);

    logic [W-1:0] mem_reg [0:1];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   cnt_reg, cnt_next;

    // Pointer and count updates.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_data   = mem_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == 2'd2);
    assign stat.empty = (cnt_reg == 2'd0);

    // The back end drains every cycle, so the queue never holds more than one entry.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && stat.full))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && stat.empty))
        else $error("queue underflow");
    a_shallow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd2)
        else $error("queue filled beyond one entry");

endmodule

// ===== sv/uvs_qsine.sv =====
// Pipelined quarter sine: Taylor series evaluated in Horner form over registered steps.
`timescale 1ns / 1ps

module uvs_qsine #(
    parameter int ANGLE_BITS = uvs_pkg::ANGLE_BITS_DEF
) (
    input  logic                  clk,
    input  logic [ANGLE_BITS-2:0] r,
    output logic [14:0]           s
);

    localparam int QB = ANGLE_BITS - 2;
    localparam int PW = ANGLE_BITS + 30;

    logic [PW-1:0] xp;
    logic [30:0]   x0_reg;
    logic [61:0]   xsq;
    logic [30:0]   x_pipe_reg  [0:12];
    logic [31:0]   x2_pipe_reg [0:12];
    logic [30:0]   t_in [0:4];
    logic [60:0]   fin_prod;
    logic [30:0]   sres_reg;
    logic [31:0]   rnd;
    logic [14:0]   s_reg, s_next;

    // Angle in radians, Q2.30.
    always_comb
    begin
        xp  = PW'(r) * PW'(uvs_pkg::HALF_PI_Q30);
        xsq = 62'(x0_reg) * 62'(x0_reg);
    end

    always_ff @(posedge clk)
    begin
        x0_reg         <= xp[QB+30:QB];
        x_pipe_reg[0]  <= x0_reg;
        x2_pipe_reg[0] <= xsq[61:30];
    end

    // x and x squared ride along with the series steps.
    genvar n;
    generate
        for (n = 1; n <= 12; n++)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                x_pipe_reg[n]  <= x_pipe_reg[n-1];
                x2_pipe_reg[n] <= x2_pipe_reg[n-1];
            end
        end
    endgenerate

    assign t_in[0] = uvs_pkg::ONE_Q30;

    // Each step: multiply, divide by a constant through its reciprocal, correct the quotient and subtract it from one.
    genvar j;
    generate
        for (j = 0; j < 4; j++)
        begin : g_step
            localparam logic [6:0]  K = uvs_pkg::step_div(j);
            localparam logic [29:0] R = uvs_pkg::step_recip(j);

            logic [62:0] vp;
            logic [31:0] v_reg;
            logic [61:0] qp;
            logic [31:0] vb_reg;
            logic [29:0] q0_reg;
            logic [33:0] rem;
            logic [29:0] q;
            logic [30:0] t_next;
            logic [30:0] t_reg;

            always_comb
            begin
                vp     = 63'(x2_pipe_reg[3*j]) * 63'(t_in[j]);
                qp     = 62'(v_reg) * 62'(R);
                rem    = 34'(vb_reg) - 34'(q0_reg) * 34'(K);
                q      = (rem >= 34'(K)) ? q0_reg + 30'd1 : q0_reg;
                t_next = uvs_pkg::ONE_Q30 - 31'(q);
            end

            always_ff @(posedge clk)
            begin
                v_reg  <= vp[61:30];
                vb_reg <= v_reg;
                q0_reg <= qp[61:32];
                t_reg  <= t_next;
            end

            assign t_in[j+1] = t_reg;
        end
    endgenerate

    // Final product, rounding to Q2.14 and saturation at one.
    always_comb
    begin
        fin_prod = 61'(x_pipe_reg[12]) * 61'(t_in[4]);
        rnd      = 32'(sres_reg) + 32'd32768;
        s_next   = (rnd[31:16] > 16'd16384) ? 15'd16384 : rnd[30:16];
    end

    always_ff @(posedge clk)
    begin
        sres_reg <= fin_prod[60:30];
        s_reg    <= s_next;
    end

    assign s = s_reg;

endmodule

// ===== sv/uvs_back.sv =====
// Back end: sine and cosine of both angles, normal, tangent and scaled position.
`timescale 1ns / 1ps

module uvs_back #(
    parameter int ANGLE_BITS = uvs_pkg::ANGLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [uvs_pkg::TEX_W-1:0]        in_tex_u,
    input  logic [uvs_pkg::TEX_W-1:0]        in_tex_v,
    input  logic [ANGLE_BITS-1:0]            theta,
    input  logic [ANGLE_BITS-1:0]            phi,
    input  logic [uvs_pkg::RAD_W-1:0]        sphere_radius,
    output logic                             done,
    output logic signed [uvs_pkg::POS_W-1:0] pos_x,
    output logic signed [uvs_pkg::POS_W-1:0] pos_y,
    output logic signed [uvs_pkg::POS_W-1:0] pos_z,
    output logic signed [uvs_pkg::NRM_W-1:0] norm_x,
    output logic signed [uvs_pkg::NRM_W-1:0] norm_y,
    output logic signed [uvs_pkg::NRM_W-1:0] norm_z,
    output logic signed [uvs_pkg::NRM_W-1:0] tan_x,
    output logic signed [uvs_pkg::NRM_W-1:0] tan_z,
    output logic [uvs_pkg::TEX_W-1:0]        tex_u,
    output logic [uvs_pkg::TEX_W-1:0]        tex_v
);

    localparam int QB = ANGLE_BITS - 2;
    localparam int QL = uvs_pkg::QS_LAT;
    localparam int NW = uvs_pkg::NRM_W;
    localparam int TW = uvs_pkg::TEX_W;

    logic [ANGLE_BITS-2:0] ra_t, rb_t, ra_p, rb_p;
    logic [14:0]           sa_t, sb_t, sa_p, sb_p;

    logic [1:0]    qt_dly_reg [0:QL-1];
    logic [1:0]    qp_dly_reg [0:QL-1];
    logic [TW-1:0] tu_dly_reg [0:QL+2];
    logic [TW-1:0] tv_dly_reg [0:QL+2];
    logic [QL+2:0] vld_reg, vld_next;

    logic signed [NW-1:0] st_reg, ct_reg, sp_reg, cp_reg;
    logic signed [NW-1:0] st_next, ct_next, sp_next, cp_next;
    logic signed [17:0]   nx_full, nz_full, px_full, py_full, pz_full;
    logic signed [NW-1:0] nx_reg, ny_reg, nz_reg, tx_reg, tz_reg;
    logic signed [NW-1:0] nx_o_reg, ny_o_reg, nz_o_reg, tx_o_reg, tz_o_reg;
    logic signed [uvs_pkg::POS_W-1:0] px_reg, py_reg, pz_reg;
    logic [17:0]          rad_ext;

    // Quadrant selection of the two quarter sines.
    function automatic logic [2*NW-1:0] quad_sel(input logic [1:0] quad,
                                                 input logic [14:0] sa,
                                                 input logic [14:0] sb);
        logic signed [NW-1:0] a;
        logic signed [NW-1:0] b;
        logic signed [NW-1:0] sn;
        logic signed [NW-1:0] cs;
        a = $signed(NW'(sa));
        b = $signed(NW'(sb));
        case (quad)
            2'd0:
            begin
                sn = a;
                cs = b;
            end
            2'd1:
            begin
                sn = b;
                cs = -a;
            end
            2'd2:
            begin
                sn = -a;
                cs = -b;
            end
            default:
            begin
                sn = -b;
                cs = a;
            end
        endcase
        return {sn, cs};
    endfunction

    // Split phases into quadrant and remainder, with the complementary remainder.
    always_comb
    begin
        ra_t = {1'b0, theta[QB-1:0]};
        rb_t = (ANGLE_BITS-1)'(1 << QB) - ra_t;
        ra_p = {1'b0, phi[QB-1:0]};
        rb_p = (ANGLE_BITS-1)'(1 << QB) - ra_p;
    end

    uvs_qsine #(.ANGLE_BITS(ANGLE_BITS)) u_qs_ta (.clk(clk), .r(ra_t), .s(sa_t));
    uvs_qsine #(.ANGLE_BITS(ANGLE_BITS)) u_qs_tb (.clk(clk), .r(rb_t), .s(sb_t));
    uvs_qsine #(.ANGLE_BITS(ANGLE_BITS)) u_qs_pa (.clk(clk), .r(ra_p), .s(sa_p));
    uvs_qsine #(.ANGLE_BITS(ANGLE_BITS)) u_qs_pb (.clk(clk), .r(rb_p), .s(sb_p));

    // Quadrants and texture coordinates wait alongside the sine pipelines.
    always_ff @(posedge clk)
    begin
        qt_dly_reg[0] <= theta[ANGLE_BITS-1:ANGLE_BITS-2];
        qp_dly_reg[0] <= phi[ANGLE_BITS-1:ANGLE_BITS-2];
        tu_dly_reg[0] <= in_tex_u;
        tv_dly_reg[0] <= in_tex_v;
        for (int k = 1; k < QL; k++)
        begin
            qt_dly_reg[k] <= qt_dly_reg[k-1];
            qp_dly_reg[k] <= qp_dly_reg[k-1];
        end
        for (int k = 1; k < QL + 3; k++)
        begin
            tu_dly_reg[k] <= tu_dly_reg[k-1];
            tv_dly_reg[k] <= tv_dly_reg[k-1];
        end
    end

    // Signed sine and cosine of both angles.
    always_comb
    begin
        {st_next, ct_next} = quad_sel(qt_dly_reg[QL-1], sa_t, sb_t);
        {sp_next, cp_next} = quad_sel(qp_dly_reg[QL-1], sa_p, sb_p);
    end

    // Normal and position products, and the valid shift.
    always_comb
    begin
        nx_full = uvs_pkg::mul_rnd14(18'(sp_reg), 18'(ct_reg));
        nz_full = uvs_pkg::mul_rnd14(18'(sp_reg), 18'(st_reg));
        rad_ext = {2'b00, sphere_radius};
        px_full = uvs_pkg::mul_rnd14($signed(rad_ext), 18'(nx_reg));
        py_full = uvs_pkg::mul_rnd14($signed(rad_ext), 18'(ny_reg));
        pz_full = uvs_pkg::mul_rnd14($signed(rad_ext), 18'(nz_reg));
        vld_next = {vld_reg[QL+1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        st_reg   <= st_next;
        ct_reg   <= ct_next;
        sp_reg   <= sp_next;
        cp_reg   <= cp_next;
        nx_reg   <= nx_full[NW-1:0];
        nz_reg   <= nz_full[NW-1:0];
        ny_reg   <= cp_reg;
        tx_reg   <= -st_reg;
        tz_reg   <= ct_reg;
        px_reg   <= px_full[uvs_pkg::POS_W-1:0];
        py_reg   <= py_full[uvs_pkg::POS_W-1:0];
        pz_reg   <= pz_full[uvs_pkg::POS_W-1:0];
        nx_o_reg <= nx_reg;
        ny_o_reg <= ny_reg;
        nz_o_reg <= nz_reg;
        tx_o_reg <= tx_reg;
        tz_o_reg <= tz_reg;
    end

    // Valid bits follow the transactions through the back end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign done   = vld_reg[QL+2];
    assign pos_x  = px_reg;
    assign pos_y  = py_reg;
    assign pos_z  = pz_reg;
    assign norm_x = nx_o_reg;
    assign norm_y = ny_o_reg;
    assign norm_z = nz_o_reg;
    assign tan_x  = tx_o_reg;
    assign tan_z  = tz_o_reg;
    assign tex_u  = tu_dly_reg[QL+2];
    assign tex_v  = tv_dly_reg[QL+2];

endmodule

// ===== sv/uv_sphere_vertex_generator.sv =====
// Top level: APB registers, front end, queue and back end of the UV sphere generator.
// Throughput: one vertex per cycle; busy stays low because the back end drains every cycle.
// Path of a vertex: the numerator registers, the bit-per-stage index dividers of depth
// QW = max(17, ANGLE_BITS + 1), the queue storage register, the sine series of 16 stages
// and 3 more stages for the normal and position products.
// Reset (rst_n low, asynchronous) empties all pipelines and restores the registers to
// radius 256, 32 longitude segments and 16 latitude bands; results cannot be stalled.
`timescale 1ns / 1ps

module uv_sphere_vertex_generator #(
    parameter int MAX_STEPS  = uvs_pkg::MAX_STEPS_DEF,
    parameter int ANGLE_BITS = uvs_pkg::ANGLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [3:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             start,
    output logic                             busy,
    input  logic [uvs_pkg::IDX_W-1:0]        lat_index,
    input  logic [uvs_pkg::IDX_W-1:0]        lon_index,
    output logic                             done,
    output logic signed [uvs_pkg::POS_W-1:0] pos_x,
    output logic signed [uvs_pkg::POS_W-1:0] pos_y,
    output logic signed [uvs_pkg::POS_W-1:0] pos_z,
    output logic signed [uvs_pkg::NRM_W-1:0] norm_x,
    output logic signed [uvs_pkg::NRM_W-1:0] norm_y,
    output logic signed [uvs_pkg::NRM_W-1:0] norm_z,
    output logic signed [uvs_pkg::NRM_W-1:0] tan_x,
    output logic signed [uvs_pkg::NRM_W-1:0] tan_z,
    output logic [uvs_pkg::TEX_W-1:0]        tex_u,
    output logic [uvs_pkg::TEX_W-1:0]        tex_v
);

    localparam int TW = uvs_pkg::TEX_W;
    localparam int QDW = 2 * TW + 2 * ANGLE_BITS;

    logic [uvs_pkg::RAD_W-1:0] radius_reg;
    logic [uvs_pkg::CNT_W-1:0] lon_cnt_reg;
    logic [uvs_pkg::CNT_W-1:0] lat_cnt_reg;
    logic                      wr_en;
    logic                      take;

    logic                      f_valid;
    logic [TW-1:0]             f_tex_u, f_tex_v;
    logic [ANGLE_BITS-1:0]     f_theta, f_phi;

    logic [QDW-1:0]            q_in, q_out;
    uvs_pkg::q_stat_t          q_stat;
    logic                      q_pop;

    // Configuration writes complete in the access phase.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= uvs_pkg::RADIUS_RST;
            lon_cnt_reg <= uvs_pkg::LON_RST;
            lat_cnt_reg <= uvs_pkg::LAT_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                uvs_pkg::REG_RADIUS: radius_reg  <= pwdata[uvs_pkg::RAD_W-1:0];
                uvs_pkg::REG_LON:    lon_cnt_reg <= pwdata[uvs_pkg::CNT_W-1:0];
                uvs_pkg::REG_LAT:    lat_cnt_reg <= pwdata[uvs_pkg::CNT_W-1:0];
                default:             ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (paddr[3:2])
            uvs_pkg::REG_RADIUS: prdata = 32'(radius_reg);
            uvs_pkg::REG_LON:    prdata = 32'(lon_cnt_reg);
            uvs_pkg::REG_LAT:    prdata = 32'(lat_cnt_reg);
            default:             prdata = 32'd0;
        endcase
    end

    // A transaction is taken whenever start is high and the queue has room.
    assign busy = q_stat.full;
    assign take = start && !busy;

    uvs_front #(.MAX_STEPS(MAX_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .take            (take),
        .lat_index       (lat_index),
        .lon_index       (lon_index),
        .longitude_count (lon_cnt_reg),
        .latitude_count  (lat_cnt_reg),
        .out_valid       (f_valid),
        .tex_u           (f_tex_u),
        .tex_v           (f_tex_v),
        .theta           (f_theta),
        .phi             (f_phi)
    );

    assign q_in  = {f_tex_u, f_tex_v, f_theta, f_phi};
    assign q_pop = !q_stat.empty;

    uvs_queue #(.W(QDW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .stat      (q_stat)
    );

    uvs_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (q_pop),
        .in_tex_u      (q_out[QDW-1:QDW-TW]),
        .in_tex_v      (q_out[QDW-TW-1:2*ANGLE_BITS]),
        .theta         (q_out[2*ANGLE_BITS-1:ANGLE_BITS]),
        .phi           (q_out[ANGLE_BITS-1:0]),
        .sphere_radius (radius_reg),
        .done          (done),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .norm_x        (norm_x),
        .norm_y        (norm_y),
        .norm_z        (norm_z),
        .tan_x         (tan_x),
        .tan_z         (tan_z),
        .tex_u         (tex_u),
        .tex_v         (tex_v)
    );

endmodule

// ===== dv/uv_sphere_vertex_generator_test.sv =====
// Self-checking testbench for the UV sphere vertex generator: APB setup, vertex requests, scoreboard.
`timescale 1ns / 1ps

module uv_sphere_vertex_generator_test;

    localparam int ANG_B   = uvs_pkg::ANGLE_BITS_DEF;
    localparam int LIMIT   = 200000;
    localparam int SETTLE  = 48;

    // One vertex as seen on the result ports.
    typedef struct packed {
        logic [uvs_pkg::POS_W-1:0] pos_x;
        logic [uvs_pkg::POS_W-1:0] pos_y;
        logic [uvs_pkg::POS_W-1:0] pos_z;
        logic [uvs_pkg::NRM_W-1:0] norm_x;
        logic [uvs_pkg::NRM_W-1:0] norm_y;
        logic [uvs_pkg::NRM_W-1:0] norm_z;
        logic [uvs_pkg::NRM_W-1:0] tan_x;
        logic [uvs_pkg::NRM_W-1:0] tan_z;
        logic [uvs_pkg::TEX_W-1:0] tex_u;
        logic [uvs_pkg::TEX_W-1:0] tex_v;
    } vertex_t;

    // Vertex predictor with its own register copy and the queue of pending vertices.
    class vertex_scoreboard;
        logic [uvs_pkg::RAD_W-1:0] radius;
        logic [uvs_pkg::CNT_W-1:0] lon_cnt;
        logic [uvs_pkg::CNT_W-1:0] lat_cnt;
        vertex_t                   pending[$];
        int                        mismatches;

        function new();
            radius     = uvs_pkg::RADIUS_RST;
            lon_cnt    = uvs_pkg::LON_RST;
            lat_cnt    = uvs_pkg::LAT_RST;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] code, logic [31:0] value);
            case (code)
                uvs_pkg::REG_RADIUS: radius = value[uvs_pkg::RAD_W-1:0];
                uvs_pkg::REG_LON:    lon_cnt = value[uvs_pkg::CNT_W-1:0];
                uvs_pkg::REG_LAT:    lat_cnt = value[uvs_pkg::CNT_W-1:0];
                default:             ;
            endcase
        endfunction

        function longint unsigned steps(logic [uvs_pkg::CNT_W-1:0] c);
            if (c == 0)
                return 1;
            if (c > uvs_pkg::MAX_STEPS_DEF)
                return uvs_pkg::MAX_STEPS_DEF;
            return c;
        endfunction

        // Quarter-wave sine by a truncated Taylor series in Q2.30, rounded to Q2.14.
        function longint quarter_sine(longint unsigned r);
            longint unsigned x;
            longint unsigned x2;
            longint unsigned t;
            longint unsigned s;
            longint unsigned q;
            x  = (r * 64'd1686629713) >> (ANG_B - 2);
            x2 = (x * x) >> 30;
            t  = 64'd1 << 30;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            q  = (s + 32768) >> 16;
            if (q > 16384)
                q = 16384;
            return longint'(q);
        endfunction

        function void sin_cos(longint unsigned phase, output longint sn, output longint cs);
            longint unsigned quad;
            longint unsigned r;
            longint          a;
            longint          b;
            quad = (phase >> (ANG_B - 2)) & 3;
            r    = phase & ((64'd1 << (ANG_B - 2)) - 1);
            a    = quarter_sine(r);
            b    = quarter_sine((64'd1 << (ANG_B - 2)) - r);
            case (quad)
                0: begin sn = a;  cs = b;  end
                1: begin sn = b;  cs = -a; end
                2: begin sn = -a; cs = -b; end
                default: begin sn = -b; cs = a; end
            endcase
        endfunction

        // Product scaled down by 2^14, rounded half away from zero.
        function longint scale14(longint a, longint b);
            longint m;
            m = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + 8192) >>> 14;
            return ((a < 0) != (b < 0)) ? -m : m;
        endfunction

        // Note an accepted request and queue the vertex it should produce.
        function void note(logic [uvs_pkg::IDX_W-1:0] lat, logic [uvs_pkg::IDX_W-1:0] lon);
            longint unsigned lc, mc, a, b, th, ph;
            longint          st, ct, sp, cp, nx, ny, nz;
            vertex_t         v;
            lc = steps(lat_cnt);
            mc = steps(lon_cnt);
            a  = (lat > lc) ? lc : lat;
            b  = (lon > mc) ? mc : lon;
            th = (((b << ANG_B) + mc / 2) / mc) & ((64'd1 << ANG_B) - 1);
            ph = ((a << (ANG_B - 1)) + lc / 2) / lc;
            sin_cos(th, st, ct);
            sin_cos(ph, sp, cp);
            nx = scale14(sp, ct);
            ny = cp;
            nz = scale14(sp, st);
            v.pos_x  = uvs_pkg::POS_W'(scale14(longint'(radius), nx));
            v.pos_y  = uvs_pkg::POS_W'(scale14(longint'(radius), ny));
            v.pos_z  = uvs_pkg::POS_W'(scale14(longint'(radius), nz));
            v.norm_x = uvs_pkg::NRM_W'(nx);
            v.norm_y = uvs_pkg::NRM_W'(ny);
            v.norm_z = uvs_pkg::NRM_W'(nz);
            v.tan_x  = uvs_pkg::NRM_W'(-st);
            v.tan_z  = uvs_pkg::NRM_W'(ct);
            v.tex_u  = uvs_pkg::TEX_W'(((b << 16) + mc / 2) / mc);
            v.tex_v  = uvs_pkg::TEX_W'(65536 - ((a << 16) + lc / 2) / lc);
            pending.insert(pending.size(), v);
        endfunction

        // Compare a delivered vertex with the oldest pending one.
        function void check(vertex_t got);
            vertex_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected vertex %p", got);
                return;
            end
            want = pending.pop_front();
            if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
                got.pos_z !== want.pos_z || got.norm_x !== want.norm_x ||
                got.norm_y !== want.norm_y || got.norm_z !== want.norm_z ||
                got.tan_x !== want.tan_x || got.tan_z !== want.tan_z ||
                got.tex_u !== want.tex_u || got.tex_v !== want.tex_v) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: vertex mismatch\n  expected %p\n  actual   %p", want, got);
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [3:0]                       paddr;
    logic [31:0]                      pwdata;
    logic [31:0]                      prdata;
    logic                             pready;
    logic                             start;
    logic                             busy;
    logic [uvs_pkg::IDX_W-1:0]        lat_index;
    logic [uvs_pkg::IDX_W-1:0]        lon_index;
    logic                             done;
    logic signed [uvs_pkg::POS_W-1:0] pos_x, pos_y, pos_z;
    logic signed [uvs_pkg::NRM_W-1:0] norm_x, norm_y, norm_z, tan_x, tan_z;
    logic [uvs_pkg::TEX_W-1:0]        tex_u, tex_v;

    vertex_scoreboard sb;
    int               cycles;
    bit               allow_gaps;

    uv_sphere_vertex_generator dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .lat_index(lat_index), .lon_index(lon_index),
        .done(done), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
        .tan_x(tan_x), .tan_z(tan_z), .tex_u(tex_u), .tex_v(tex_v)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Check every vertex transaction as it is strobed out.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check({pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tan_x, tan_z, tex_u, tex_v});
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // APB write: setup cycle, then access cycle completing when pready is high.
    task automatic reg_write(logic [1:0] code, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {code, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(code, value);
    endtask

    // Wait for every pending vertex, then let the pipeline settle.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic reconfigure(logic [31:0] rad, logic [31:0] lon, logic [31:0] lat);
        drain();
        reg_write(uvs_pkg::REG_RADIUS, rad);
        reg_write(uvs_pkg::REG_LON, lon);
        reg_write(uvs_pkg::REG_LAT, lat);
    endtask

    // Present one request and hold it until the block takes the transaction.
    task automatic request(logic [uvs_pkg::IDX_W-1:0] lat, logic [uvs_pkg::IDX_W-1:0] lon);
        start     <= 1'b1;
        lat_index <= lat;
        lon_index <= lon;
        do
            @(posedge clk);
        while (busy);
        sb.note(lat, lon);
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // Random requests: mostly valid grid points, some beyond the counts.
    task automatic random_requests(int n);
        logic [uvs_pkg::IDX_W-1:0] lat;
        logic [uvs_pkg::IDX_W-1:0] lon;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                lat = uvs_pkg::IDX_W'($urandom);
                lon = uvs_pkg::IDX_W'($urandom);
            end else begin
                lat = uvs_pkg::IDX_W'($urandom_range(0, int'(sb.steps(sb.lat_cnt))));
                lon = uvs_pkg::IDX_W'($urandom_range(0, int'(sb.steps(sb.lon_cnt))));
            end
            request(lat, lon);
        end
    endtask

    initial
    begin
        sb         = new();
        allow_gaps = 1'b1;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        start      = 1'b0;
        lat_index  = '0;
        lon_index  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: poles, equator, last longitude and indices past the counts.
        request(0, 0);
        request(16, 32);
        request(8, 0);
        request(8, 8);
        request(8, 16);
        request(8, 24);
        request(4, 32);
        request(12, 5);
        request(2047, 2047);
        request(0, 2047);
        request(2047, 0);
        request(1, 31);
        request(15, 1);
        random_requests(80);

        // Largest radius and counts.
        reconfigure(32'hFFFF, 1024, 1024);
        request(1024, 1024);
        request(512, 256);
        request(1023, 1023);
        request(1, 1);
        random_requests(90);

        // Zero counts behave as a single step; zero radius.
        reconfigure(0, 0, 0);
        request(0, 0);
        request(1, 1);
        request(2047, 2047);
        random_requests(40);

        // Counts beyond the maximum are limited.
        reconfigure($urandom_range(1, 65535), 2047, 1500);
        request(2047, 2047);
        random_requests(90);

        // Unit counts and the smallest nonzero radius.
        reconfigure(1, 1, 1);
        random_requests(40);

        // Random settings, final stretch with no gaps.
        reconfigure($urandom_range(0, 65535), $urandom_range(1, 64), $urandom_range(1, 64));
        random_requests(90);
        reconfigure($urandom_range(0, 65535), $urandom_range(1, 1024), $urandom_range(1, 1024));
        allow_gaps = 1'b0;
        random_requests(100);

        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
